### rtl/core/plsl_pkg.sv
// ----------------------------------------------------------------------------
// plsl_pkg
// Shared widths, status codes, breakpoint tables and request types for the
// piecewise-linear sensor linearizer.
// ----------------------------------------------------------------------------
package plsl_pkg;

    localparam int NUM_POINTS = 15;
    localparam int NUM_SEGS   = NUM_POINTS - 1;

    localparam int VOLT_W  = 15;
    localparam int DIST_W  = 16;
    localparam int STAT_W  = 2;
    localparam int SEG_W   = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
    localparam int SLOPE_W = 24;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = VOLT_W + 1 + SLOPE_W;
    localparam int QUOT_W  = PROD_W - FRAC_W;
    localparam int SUM_W   = QUOT_W + 2;

    localparam logic [STAT_W-1:0] STATUS_VALID    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_TOO_LOW  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_TOO_HIGH = 2'd2;

    localparam logic [VOLT_W-1:0] BP_VOLT [NUM_POINTS] = '{
        15'd1948, 15'd2017, 15'd2179, 15'd2388, 15'd2550, 15'd2782, 15'd3130,
        15'd3431, 15'd3825, 15'd4428, 15'd5147, 15'd6422, 15'd8277, 15'd10364,
        15'd11407
    };

    localparam logic [DIST_W-1:0] BP_DIST [NUM_POINTS] = '{
        16'd38193, 16'd35661, 16'd33283, 16'd30648, 16'd28012, 16'd25583,
        16'd22999, 16'd20621, 16'd17882, 16'd15505, 16'd12869, 16'd10440,
        16'd7649,  16'd5117,  16'd3980
    };

    // (1/256 cm) per (1/4096 V), 16 fraction bits, rounded half away from zero
    localparam logic signed [SLOPE_W-1:0] SLOPE_ROM [NUM_SEGS] = '{
        -24'sd2404886, -24'sd962004, -24'sd826255, -24'sd1066376,
        -24'sd686151,  -24'sd486624, -24'sd517756, -24'sd455592,
        -24'sd258340,  -24'sd240268, -24'sd124853, -24'sd98604,
        -24'sd79510,   -24'sd71442
    };

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SEG_W-1:0]  seg;
        logic [VOLT_W-1:0] offset;
    } plsl_req_t;

endpackage

### rtl/core/plsl_front.sv
// ----------------------------------------------------------------------------
// plsl_front
// Classifies a voltage: range check, segment search over the breakpoints
// and offset from the segment's left breakpoint.
// ----------------------------------------------------------------------------
module plsl_front (
    input  logic [plsl_pkg::VOLT_W-1:0] voltage,
    output plsl_pkg::plsl_req_t         req
);

    logic [plsl_pkg::SEG_W-1:0]  seg;
    logic [plsl_pkg::VOLT_W-1:0] base_volt;

    always_comb
    begin
        seg = '0;
        for (int i = 1; i < plsl_pkg::NUM_SEGS; i++)
        begin
            if (plsl_pkg::BP_VOLT[i] <= voltage)
            begin
                seg = plsl_pkg::SEG_W'(i);
            end
        end
    end

    assign base_volt = plsl_pkg::BP_VOLT[seg];

    always_comb
    begin
        req.seg    = seg;
        req.offset = voltage - base_volt;
        if (voltage < plsl_pkg::BP_VOLT[0])
        begin
            req.status = plsl_pkg::STATUS_TOO_LOW;
        end
        else if (voltage > plsl_pkg::BP_VOLT[plsl_pkg::NUM_POINTS-1])
        begin
            req.status = plsl_pkg::STATUS_TOO_HIGH;
        end
        else
        begin
            req.status = plsl_pkg::STATUS_VALID;
        end
    end

endmodule

### rtl/core/plsl_queue.sv
// ----------------------------------------------------------------------------
// plsl_queue
// Two-entry request queue between the front and back parts.
// ----------------------------------------------------------------------------
module plsl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                pop,
    input  plsl_pkg::plsl_req_t wr_req,
    output plsl_pkg::plsl_req_t rd_req,
    output logic                full,
    output logic                empty
);

    plsl_pkg::plsl_req_t mem [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;

    logic do_push;
    logic do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_req  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wr_req;
        end
    end

endmodule

### rtl/core/plsl_back.sv
// ----------------------------------------------------------------------------
// plsl_back
// Two-stage interpolation: slope multiply, then rounding, base add and
// saturation into the result register.
// ----------------------------------------------------------------------------
module plsl_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  plsl_pkg::plsl_req_t         in_req,
    output logic                        done,
    output logic [plsl_pkg::DIST_W-1:0] distance,
    output logic [plsl_pkg::STAT_W-1:0] status
);

    localparam logic [plsl_pkg::PROD_W-1:0] HALF = plsl_pkg::PROD_W'(1) << (plsl_pkg::FRAC_W - 1);
    localparam logic signed [plsl_pkg::SUM_W-1:0] DIST_MAX =
        plsl_pkg::SUM_W'((1 << plsl_pkg::DIST_W) - 1);

    // stage 1
    logic                               s1_valid_reg;
    logic [plsl_pkg::STAT_W-1:0]        s1_status_reg;
    logic [plsl_pkg::DIST_W-1:0]        s1_base_reg;
    logic signed [plsl_pkg::PROD_W-1:0] s1_prod_reg;
    logic signed [plsl_pkg::PROD_W-1:0] s1_prod_next;

    // stage 2
    logic                               done_reg;
    logic [plsl_pkg::DIST_W-1:0]        dist_reg, dist_next;
    logic [plsl_pkg::STAT_W-1:0]        status_reg;

    logic [plsl_pkg::PROD_W-1:0]        mag;
    logic [plsl_pkg::PROD_W-1:0]        mag_rnd;
    logic [plsl_pkg::QUOT_W-1:0]        quot;
    logic signed [plsl_pkg::SUM_W-1:0]  sum;

    assign s1_prod_next = $signed({1'b0, in_req.offset}) * plsl_pkg::SLOPE_ROM[in_req.seg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            done_reg     <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            s1_status_reg <= in_req.status;
            s1_base_reg   <= plsl_pkg::BP_DIST[in_req.seg];
            s1_prod_reg   <= s1_prod_next;
        end
        if (s1_valid_reg)
        begin
            dist_reg   <= dist_next;
            status_reg <= s1_status_reg;
        end
    end

    always_comb
    begin
        mag     = s1_prod_reg[plsl_pkg::PROD_W-1] ? 
                  plsl_pkg::PROD_W'(-s1_prod_reg) : plsl_pkg::PROD_W'(s1_prod_reg);
        mag_rnd = mag + HALF;
        quot    = mag_rnd[plsl_pkg::PROD_W-1:plsl_pkg::FRAC_W];
        if (s1_prod_reg[plsl_pkg::PROD_W-1])
        begin
            sum = $signed({{(plsl_pkg::SUM_W-plsl_pkg::DIST_W){1'b0}}, s1_base_reg})
                - $signed({2'b00, quot});
        end
        else
        begin
            sum = $signed({{(plsl_pkg::SUM_W-plsl_pkg::DIST_W){1'b0}}, s1_base_reg})
                + $signed({2'b00, quot});
        end
        if (s1_status_reg != plsl_pkg::STATUS_VALID || sum < 0)
        begin
            dist_next = '0;
        end
        else if (sum > DIST_MAX)
        begin
            dist_next = '1;
        end
        else
        begin
            dist_next = sum[plsl_pkg::DIST_W-1:0];
        end
    end

    assign done     = done_reg;
    assign distance = dist_reg;
    assign status   = status_reg;

endmodule

### rtl/core/piecewise_linear_sensor_linearizer_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_sensor_linearizer_unit
// Maps a sensor voltage (1/4096 V) to a distance (1/256 cm) along a
// piecewise-linear calibration curve.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive voltage and raise start; the request is taken at
//   a rising edge with start high and busy low. A new request may be given
//   every cycle.
//   Result channel: done is high for exactly one cycle with distance and
//   status; results come in request order and cannot be held off.
//   Path: a taken request is classified and written into the queue, then
//   registered by the slope multiply and the round and add stages.
//   Throughput: one request per cycle, set by the single pipelined
//   multiplier of the back part, which drains the queue every cycle.
//   busy rises only if the two-entry queue is full.
//   Status 1 (below table) and 2 (above table) give distance 0.
//   Reset empties the queue and the pipeline; no result is lost or invented.
// ----------------------------------------------------------------------------
module piecewise_linear_sensor_linearizer_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [plsl_pkg::VOLT_W-1:0] voltage,
    output logic                        done,
    output logic [plsl_pkg::DIST_W-1:0] distance,
    output logic [plsl_pkg::STAT_W-1:0] status
);

    plsl_pkg::plsl_req_t front_req;
    plsl_pkg::plsl_req_t back_req;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;

    plsl_front u_front (
        .voltage (voltage),
        .req     (front_req)
    );

    assign q_push = start && !q_full;
    assign q_pop  = !q_empty;

    plsl_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .pop    (q_pop),
        .wr_req (front_req),
        .rd_req (back_req),
        .full   (q_full),
        .empty  (q_empty)
    );

    plsl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_pop),
        .in_req   (back_req),
        .done     (done),
        .distance (distance),
        .status   (status)
    );

    assign busy = q_full;

endmodule
